// ----- src/rgs_pkg.sv -----
// rgs_pkg: shared widths, constants and controller/datapath handshake types
// for the rgb gradient stepper; no dependencies
package rgs_pkg;

  localparam int unsigned CH_W      = 8;  // color channel width
  localparam int unsigned IDX_W     = 7;  // point index width on the output
  localparam int unsigned NUM_CH    = 3;  // red, green, blue
  localparam int unsigned DIV_STEPS = CH_W;  // one quotient bit per cycle
  localparam int unsigned STEP_W    = $clog2(DIV_STEPS);

  typedef struct packed {
    logic load;      // capture a new request
    logic div_step;  // one restoring divide iteration on all lanes
    logic emit;      // advance to the next color and register it
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_zero;    // request on the input carries zero divisions
    logic emit_last;  // the next emitted color closes the run
  } dp_status_t;

endpackage

// ----- src/rgs_if.sv -----
// rgs_in_if / rgs_out_if: valid-ready channels for requests and colors
// depends on rgs_pkg
interface rgs_in_if import rgs_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] start_red;
  logic [CH_W-1:0] start_green;
  logic [CH_W-1:0] start_blue;
  logic [CH_W-1:0] end_red;
  logic [CH_W-1:0] end_green;
  logic [CH_W-1:0] end_blue;
  logic [CH_W-1:0] divisions;

  modport source (
    output valid, start_red, start_green, start_blue,
    output end_red, end_green, end_blue, divisions,
    input  ready
  );
  modport sink (
    input  valid, start_red, start_green, start_blue,
    input  end_red, end_green, end_blue, divisions,
    output ready
  );
endinterface

interface rgs_out_if import rgs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CH_W-1:0]  mid_red;
  logic [CH_W-1:0]  mid_green;
  logic [CH_W-1:0]  mid_blue;
  logic [IDX_W-1:0] point_index;
  logic             last_point;

  modport source (
    output valid, mid_red, mid_green, mid_blue, point_index, last_point,
    input  ready
  );
  modport sink (
    input  valid, mid_red, mid_green, mid_blue, point_index, last_point,
    output ready
  );
endinterface

// ----- src/rgs_datapath.sv -----
// rgs_datapath: three-lane serial signed divider, color accumulators and
// output register; depends on rgs_pkg, driven by rgs_ctrl commands
module rgs_datapath import rgs_pkg::*; #(
  parameter int unsigned MAX_DIVISIONS = 64
) (
  input  logic             clk_i,
  input  ctrl_cmd_t        cmd_i,
  output dp_status_t       status_o,
  input  logic [CH_W-1:0]  start_red_i,
  input  logic [CH_W-1:0]  start_green_i,
  input  logic [CH_W-1:0]  start_blue_i,
  input  logic [CH_W-1:0]  end_red_i,
  input  logic [CH_W-1:0]  end_green_i,
  input  logic [CH_W-1:0]  end_blue_i,
  input  logic [CH_W-1:0]  divisions_i,
  output logic [CH_W-1:0]  mid_red_o,
  output logic [CH_W-1:0]  mid_green_o,
  output logic [CH_W-1:0]  mid_blue_o,
  output logic [IDX_W-1:0] point_index_o,
  output logic             last_point_o
);

  localparam int unsigned CNT_W = $clog2(MAX_DIVISIONS + 1);
  localparam int unsigned DVS_W = $clog2(MAX_DIVISIONS + 2);

  logic [CH_W-1:0]  start_ch [NUM_CH];
  logic [CH_W-1:0]  end_ch   [NUM_CH];

  logic [CNT_W-1:0] n_sat;
  logic [CNT_W-1:0] n_q, n_d;
  logic [CNT_W-1:0] k_q, k_d;
  logic [DVS_W-1:0] divisor;

  logic [CH_W-1:0]  quo_q [NUM_CH];  // magnitude, then quotient bits
  logic [CH_W-1:0]  quo_d [NUM_CH];
  logic [CH_W-1:0]  rem_q [NUM_CH];
  logic [CH_W-1:0]  rem_d [NUM_CH];
  logic             neg_q [NUM_CH];
  logic             neg_d [NUM_CH];
  logic [CH_W-1:0]  acc_q [NUM_CH];
  logic [CH_W-1:0]  acc_d [NUM_CH];
  logic [CH_W-1:0]  mid_q [NUM_CH];
  logic [CH_W-1:0]  mid_d [NUM_CH];
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             last_q, last_d;

  logic [CH_W:0]    diff   [NUM_CH];
  logic [CH_W:0]    rem_sh [NUM_CH];
  logic [CH_W:0]    rem_sub[NUM_CH];
  logic [CH_W-1:0]  step   [NUM_CH];

  assign start_ch[0] = start_red_i;
  assign start_ch[1] = start_green_i;
  assign start_ch[2] = start_blue_i;
  assign end_ch[0]   = end_red_i;
  assign end_ch[1]   = end_green_i;
  assign end_ch[2]   = end_blue_i;

  assign n_sat = (divisions_i > CH_W'(MAX_DIVISIONS)) ? CNT_W'(MAX_DIVISIONS)
                                                      : CNT_W'(divisions_i);
  assign divisor = DVS_W'(n_q) + DVS_W'(1);

  assign status_o.in_zero   = (divisions_i == '0);
  assign status_o.emit_last = ((k_q + CNT_W'(1)) == n_q);

  always_comb begin
    n_d    = n_q;
    k_d    = k_q;
    idx_d  = idx_q;
    last_d = last_q;
    for (int i = 0; i < NUM_CH; i++) begin
      diff[i]    = {1'b0, end_ch[i]} - {1'b0, start_ch[i]};
      rem_sh[i]  = {rem_q[i], quo_q[i][CH_W-1]};
      rem_sub[i] = rem_sh[i] - (CH_W + 1)'(divisor);
      step[i]    = neg_q[i] ? (CH_W'(0) - quo_q[i]) : quo_q[i];
      quo_d[i]   = quo_q[i];
      rem_d[i]   = rem_q[i];
      neg_d[i]   = neg_q[i];
      acc_d[i]   = acc_q[i];
      mid_d[i]   = mid_q[i];
      if (cmd_i.load) begin
        neg_d[i] = diff[i][CH_W];
        quo_d[i] = diff[i][CH_W] ? CH_W'(~diff[i] + 1'b1) : diff[i][CH_W-1:0];
        rem_d[i] = '0;
        acc_d[i] = start_ch[i];
      end else if (cmd_i.div_step) begin
        if (rem_sh[i] >= (CH_W + 1)'(divisor)) begin
          rem_d[i] = rem_sub[i][CH_W-1:0];
          quo_d[i] = {quo_q[i][CH_W-2:0], 1'b1};
        end else begin
          rem_d[i] = rem_sh[i][CH_W-1:0];
          quo_d[i] = {quo_q[i][CH_W-2:0], 1'b0};
        end
      end else if (cmd_i.emit) begin
        acc_d[i] = acc_q[i] + step[i];
        mid_d[i] = acc_d[i];
      end
    end
    if (cmd_i.load) begin
      n_d = n_sat;
      k_d = '0;
    end else if (cmd_i.emit) begin
      k_d    = k_q + CNT_W'(1);
      idx_d  = IDX_W'(k_d);
      last_d = status_o.emit_last;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q    <= n_d;
    k_q    <= k_d;
    idx_q  <= idx_d;
    last_q <= last_d;
    for (int i = 0; i < NUM_CH; i++) begin
      quo_q[i] <= quo_d[i];
      rem_q[i] <= rem_d[i];
      neg_q[i] <= neg_d[i];
      acc_q[i] <= acc_d[i];
      mid_q[i] <= mid_d[i];
    end
  end

  assign mid_red_o     = mid_q[0];
  assign mid_green_o   = mid_q[1];
  assign mid_blue_o    = mid_q[2];
  assign point_index_o = idx_q;
  assign last_point_o  = last_q;

endmodule

// ----- src/rgs_ctrl.sv -----
// rgs_ctrl: request/divide/emit state machine and output valid register
// depends on rgs_pkg, commands rgs_datapath
module rgs_ctrl import rgs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_STEPS - 1);

  logic [1:0]        state_q, state_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;
  logic              out_free;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          if (!status_i.in_zero) begin
            state_d = S_DIV;
          end
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + STEP_W'(1);
        if (cnt_q == STEP_LAST) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          if (status_i.emit_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTH
  a_emit_into_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> (!out_valid_q || out_ready_i))
    else $error("color emitted over a pending transaction");

  a_div_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && cnt_q == STEP_LAST) |=> (state_q == S_EMIT))
    else $error("divide did not finish after all quotient bits");

  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> out_valid_q)
    else $error("pending color dropped");

  a_no_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> !cmd_o.emit && !cmd_o.div_step)
    else $error("request captured while busy");
`endif

endmodule

// ----- src/rgb_gradient_stepper.sv -----
// rgb_gradient_stepper: top level, linear color gradient generator
// depends on rgs_pkg, rgs_if, rgs_ctrl and rgs_datapath
//
// usage:
//   in_i carries one request: start color, end color and a division count N
//   (saturated to MAX_DIVISIONS). out_o returns N colors start + k*q per
//   channel, k = 1..N, with q = (end - start) / (N + 1) truncated toward
//   zero; point_index gives k and last_point marks the final color.
//   a request with N = 0 is taken and produces nothing.
// timing:
//   a request is taken only while no run is in progress; the divide then
//   runs at one quotient bit per cycle, all three channels in parallel,
//   and the colors follow, one color per cycle while out_o.ready is high.
//   the next request can be taken while the final color still waits.
// stalls and reset:
//   a stalled color holds in the output register and the run pauses.
//   reset clears the controller and drops any run and pending color.
module rgb_gradient_stepper import rgs_pkg::*; #(
  parameter int unsigned MAX_DIVISIONS = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  rgs_in_if.sink    in_i,
  rgs_out_if.source out_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  rgs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  rgs_datapath #(
    .MAX_DIVISIONS (MAX_DIVISIONS)
  ) u_datapath (
    .clk_i         (clk_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .start_red_i   (in_i.start_red),
    .start_green_i (in_i.start_green),
    .start_blue_i  (in_i.start_blue),
    .end_red_i     (in_i.end_red),
    .end_green_i   (in_i.end_green),
    .end_blue_i    (in_i.end_blue),
    .divisions_i   (in_i.divisions),
    .mid_red_o     (out_o.mid_red),
    .mid_green_o   (out_o.mid_green),
    .mid_blue_o    (out_o.mid_blue),
    .point_index_o (out_o.point_index),
    .last_point_o  (out_o.last_point)
  );

endmodule

// ----- tb/sv/gradient_checker.sv -----
`timescale 1ns / 100ps
// gradient_checker: watches the request and color channels of the gradient stepper,
// predicts every color of each accepted request and compares it field by field
// depends on rgs_pkg and the rgs_in_if / rgs_out_if interfaces
module gradient_checker import rgs_pkg::*; #(
  parameter int unsigned MAX_DIVISIONS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rgs_in_if           in_i,
  rgs_out_if          out_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned color_count_o
);

  typedef struct packed {
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
    logic [IDX_W-1:0] index;
    logic             last;
  } gradient_color_t;

  gradient_color_t expected_colors[$];
  gradient_color_t want;
  int unsigned     fail_count  = 0;
  int unsigned     color_count = 0;
  int              run_len;
  int              step_r;
  int              step_g;
  int              step_b;

  assign fail_count_o  = fail_count;
  assign pending_o     = expected_colors.size();
  assign color_count_o = color_count;

  // signed step, truncated toward zero
  function automatic int channel_step(logic [CH_W-1:0] from_c, logic [CH_W-1:0] to_c,
                                      int divisor);
    int diff;
    diff = int'(to_c) - int'(from_c);
    return diff / divisor;
  endfunction

  function automatic logic [CH_W-1:0] channel_at(logic [CH_W-1:0] from_c, int step, int k);
    int v;
    v = int'(from_c) + k * step;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[CH_W-1:0];
  endfunction

  function automatic void check_field(string name, logic [CH_W-1:0] exp_v,
                                      logic [CH_W-1:0] act_v);
    if (exp_v !== act_v) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_colors.delete();
    end else begin
      if (out_i.valid && out_i.ready) begin
        color_count++;
        if (expected_colors.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected color, expected none, actual %0d/%0d/%0d k=%0d last=%0b",
                   $time, out_i.mid_red, out_i.mid_green, out_i.mid_blue,
                   out_i.point_index, out_i.last_point);
        end else begin
          want = expected_colors.pop_front();
          check_field("mid_red", want.red, out_i.mid_red);
          check_field("mid_green", want.green, out_i.mid_green);
          check_field("mid_blue", want.blue, out_i.mid_blue);
          check_field("point_index", CH_W'(want.index), CH_W'(out_i.point_index));
          check_field("last_point", CH_W'(want.last), CH_W'(out_i.last_point));
        end
      end
      if (in_i.valid && in_i.ready) begin
        run_len = int'(in_i.divisions);
        if (run_len > int'(MAX_DIVISIONS)) run_len = MAX_DIVISIONS;
        if (run_len > 0) begin
          step_r = channel_step(in_i.start_red, in_i.end_red, run_len + 1);
          step_g = channel_step(in_i.start_green, in_i.end_green, run_len + 1);
          step_b = channel_step(in_i.start_blue, in_i.end_blue, run_len + 1);
          for (int k = 1; k <= run_len; k++) begin
            want.red   = channel_at(in_i.start_red, step_r, k);
            want.green = channel_at(in_i.start_green, step_g, k);
            want.blue  = channel_at(in_i.start_blue, step_b, k);
            want.index = IDX_W'(k);
            want.last  = (k == run_len);
            expected_colors.push_back(want);
          end
        end
      end
    end
  end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// testbench: drives gradient requests with random gaps and color back-pressure into
// rgb_gradient_stepper and reports the verdict; depends on rgs_pkg, the rgs interfaces,
// rgb_gradient_stepper and gradient_checker
module testbench;
  import rgs_pkg::*;

  localparam int unsigned MAX_DIV          = 64;
  localparam int unsigned LONG_HOLD_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT      = 2_000_000;
  localparam int unsigned RANDOM_REQUESTS  = 330;
  localparam int unsigned PHASES           = 6;

  typedef struct packed {
    logic [CH_W-1:0] sr;
    logic [CH_W-1:0] sg;
    logic [CH_W-1:0] sb;
    logic [CH_W-1:0] er;
    logic [CH_W-1:0] eg;
    logic [CH_W-1:0] eb;
    logic [CH_W-1:0] divs;
  } gradient_request_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  bit          tx_gap_on   = 1'b0;
  bit          rx_stall_on = 1'b0;
  bit          long_hold   = 1'b0;
  int unsigned stall_left  = 0;
  int unsigned cycle_count = 0;
  int unsigned sent_reqs   = 0;
  int unsigned empty_reqs  = 0;
  int unsigned sat_reqs    = 0;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned color_count;

  rgs_in_if  in_ch ();
  rgs_out_if out_ch ();

  rgb_gradient_stepper #(
    .MAX_DIVISIONS(MAX_DIV)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  gradient_checker #(
    .MAX_DIVISIONS(MAX_DIV)
  ) checker_inst (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_ch),
    .out_i        (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .color_count_o(color_count)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d colors still expected", cycle_count, pending);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 20);
  endfunction

  function automatic logic [CH_W-1:0] pick_channel();
    logic [CH_W-1:0] v;
    int unsigned     r;
    r = $urandom_range(0, 99);
    v = CH_W'($urandom_range(0, 255));
    if (r < 10) v = '0;
    else if (r < 20) v = '1;
    return v;
  endfunction

  function automatic gradient_request_t random_request();
    gradient_request_t req;
    int unsigned       r;
    req.sr = pick_channel();
    req.sg = pick_channel();
    req.sb = pick_channel();
    req.er = pick_channel();
    req.eg = pick_channel();
    req.eb = pick_channel();
    if ($urandom_range(0, 9) == 0) begin
      req.er = req.sr;
      req.eg = req.sg;
      req.eb = req.sb;
    end
    r = $urandom_range(0, 99);
    if (r < 10) req.divs = '0;
    else if (r < 65) req.divs = CH_W'($urandom_range(1, 8));
    else if (r < 88) req.divs = CH_W'($urandom_range(9, 63));
    else if (r < 94) req.divs = CH_W'(MAX_DIV);
    else req.divs = CH_W'($urandom_range(MAX_DIV + 1, 255));
    return req;
  endfunction

  function automatic gradient_request_t req_of(int sr, int sg, int sb, int er, int eg,
                                               int eb, int divs);
    gradient_request_t req;
    req.sr   = sr[CH_W-1:0];
    req.sg   = sg[CH_W-1:0];
    req.sb   = sb[CH_W-1:0];
    req.er   = er[CH_W-1:0];
    req.eg   = eg[CH_W-1:0];
    req.eb   = eb[CH_W-1:0];
    req.divs = divs[CH_W-1:0];
    return req;
  endfunction

  task automatic offer(input gradient_request_t req);
    in_ch.valid       <= 1'b1;
    in_ch.start_red   <= req.sr;
    in_ch.start_green <= req.sg;
    in_ch.start_blue  <= req.sb;
    in_ch.end_red     <= req.er;
    in_ch.end_green   <= req.eg;
    in_ch.end_blue    <= req.eb;
    in_ch.divisions   <= req.divs;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
    sent_reqs++;
    if (req.divs == 0) empty_reqs++;
    else if (req.divs > MAX_DIV) sat_reqs++;
    if (tx_gap_on && $urandom_range(0, 99) < 35) begin
      in_ch.valid <= 1'b0;
      repeat (pick_gap()) @(negedge clk_i);
    end
  endtask

  // color receiver
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_hold) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(negedge clk_i);
        long_hold = 1'b0;
        out_ch.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (rx_stall_on && $urandom_range(0, 99) < 25) begin
        stall_left = pick_gap() - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    rst_ni            = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.start_red   = '0;
    in_ch.start_green = '0;
    in_ch.start_blue  = '0;
    in_ch.end_red     = '0;
    in_ch.end_green   = '0;
    in_ch.end_blue    = '0;
    in_ch.divisions   = '0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    offer(req_of(10, 20, 30, 200, 100, 50, 0));
    offer(req_of(0, 0, 0, 255, 255, 255, 1));
    offer(req_of(255, 255, 255, 0, 0, 0, 1));
    offer(req_of(0, 0, 0, 255, 255, 255, 64));
    offer(req_of(255, 255, 255, 0, 0, 0, 64));
    offer(req_of(0, 255, 128, 255, 0, 128, 65));
    offer(req_of(255, 0, 0, 0, 255, 255, 255));
    offer(req_of(1, 2, 3, 254, 253, 252, 128));
    offer(req_of(77, 77, 77, 77, 77, 77, 10));
    offer(req_of(200, 100, 50, 100, 200, 49, 2));
    offer(req_of(100, 100, 100, 105, 95, 101, 10));
    offer(req_of(0, 128, 255, 255, 127, 0, 63));
    offer(req_of(0, 0, 0, 3, 6, 9, 2));
    offer(req_of(255, 255, 255, 0, 0, 0, 0));
    offer(req_of(0, 0, 0, 0, 0, 0, 1));
    offer(req_of(85, 170, 85, 170, 85, 170, 170));
    offer(req_of(170, 85, 170, 85, 170, 85, 85));
    offer(req_of(1, 254, 128, 254, 1, 127, 3));
    offer(req_of(255, 0, 255, 0, 255, 0, 64));

    for (int p = 0; p < PHASES; p++) begin
      tx_gap_on   = p[0];
      rx_stall_on = p[1];
      // sender waits for every color before this phase
      if (p == 4) begin
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge clk_i);
      end
      // receiver blocks while requests keep coming
      if (p == 2) long_hold = 1'b1;
      for (int i = 0; i < RANDOM_REQUESTS / PHASES; i++) offer(random_request());
    end

    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);

    $display("%0d requests sent (%0d empty, %0d saturated), %0d colors checked",
             sent_reqs, empty_reqs, sat_reqs, color_count);
    $display("random gaps and stalls on both channels, one long output hold, one drain pause");
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
